FILE: hw/rtl/bwt_pkg.sv
// Package for the inverse BWT decoder: sizes, field widths, status codes and modes.
// No dependencies.
`default_nettype none
package bwt_pkg;
    localparam int MaxLen   = 1024;
    localparam int AddrW    = $clog2(MaxLen);
    localparam int LenW     = AddrW + 1;
    localparam int NSym     = 256;
    localparam int SymW     = 8;
    localparam int RankW    = LenW;
    localparam int PosW     = 10;
    localparam int StatW    = 2;

    localparam logic [StatW-1:0] STAT_OK    = 2'd0;
    localparam logic [StatW-1:0] STAT_EMPTY = 2'd1;
    localparam logic [StatW-1:0] STAT_TRUNC = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;
endpackage
`default_nettype wire

FILE: hw/rtl/bwt_inverse_decoder.sv
// Inverse BWT decoder top level: controller plus the block's memories.
// Depends on bwt_pkg and bwt_ram.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_axis  | in  | symbol[7:0]                                 | mode, final_req
//  m_axis  | out | byte_out[7:0], position[17:8]               | end_of_text, status[2:1]
//
// Load: a count RAM read, then column, rank and count written back. Read: a text
// RAM read, then the result register is filled. Final load: 256-entry start table
// sweep, then one LF step per block byte (one row read, one start table read).
// New block after a decode: 256-entry count clearing sweep before the load.
// Reset: control state cleared; memories hold garbage except counts (swept).
// Stalls: one result register; input is taken only when it is empty.
`default_nettype none
module bwt_inverse_decoder
    import bwt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // symbol
    input  wire logic [1:0]  s_axis_tuser,   // mode, final_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // byte_out, position, zero pad
    output logic      [2:0]  m_axis_tuser    // end_of_text, status
);
    // controller states
    localparam logic [3:0] S_CLR   = 4'd0;  // clear counts sweep
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LCNT  = 4'd2;  // wait count read
    localparam logic [3:0] S_LWR   = 4'd3;  // write col/rank/count
    localparam logic [3:0] S_PFX   = 4'd4;  // prefix sums sweep
    localparam logic [3:0] S_WROW  = 4'd6;  // row read issued
    localparam logic [3:0] S_WST   = 4'd7;  // start read issued
    localparam logic [3:0] S_RD    = 4'd8;  // text read issued
    localparam logic [3:0] S_RDW   = 4'd9;
    localparam logic [3:0] S_WNXT  = 4'd10;

    logic [3:0]      state_reg, state_next;
    logic [LenW-1:0] len_reg, len_next;
    logic [LenW-1:0] rp_reg, rp_next;
    logic            ovf_reg, ovf_next;
    logic            dv_reg, dv_next;
    logic            pend_reg, pend_next;   // load waiting behind a clear
    logic [SymW-1:0] sym_reg, sym_next;
    logic            fin_reg, fin_next;
    logic [8:0]      idx_reg, idx_next;     // sweep index, one extra bit
    logic [LenW-1:0] sum_reg, sum_next;
    logic            found_reg, found_next;
    logic [SymW-1:0] small_reg, small_next;
    logic [LenW-1:0] row_reg, row_next;
    logic [LenW-1:0] k_reg, k_next;
    logic [RankW-1:0] rk_reg, rk_next;
    logic            ov_reg, ov_next;
    logic [23:0]     od_reg, od_next;
    logic [2:0]      ou_reg, ou_next;

    // memories
    logic             col_we, rnk_we, cnt_we, st_we, txt_we;
    logic [AddrW-1:0] col_wa, col_ra, txt_wa, txt_ra;
    logic [SymW-1:0]  col_wd, col_rd, txt_wd, txt_rd;
    logic [RankW-1:0] rnk_wd, rnk_rd;
    logic [7:0]       cnt_wa, cnt_ra, st_wa, st_ra;
    logic [LenW-1:0]  cnt_wd, cnt_rd, st_wd, st_rd;

    bwt_ram #(.Width(SymW), .Depth(MaxLen)) u_col (.aclk, .we(col_we), .waddr(col_wa),
        .wdata(col_wd), .raddr(col_ra), .rdata(col_rd));
    bwt_ram #(.Width(RankW), .Depth(MaxLen)) u_rnk (.aclk, .we(rnk_we), .waddr(col_wa),
        .wdata(rnk_wd), .raddr(col_ra), .rdata(rnk_rd));
    bwt_ram #(.Width(LenW), .Depth(NSym)) u_cnt (.aclk, .we(cnt_we), .waddr(cnt_wa),
        .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
    bwt_ram #(.Width(LenW), .Depth(NSym)) u_st (.aclk, .we(st_we), .waddr(st_wa),
        .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
    bwt_ram #(.Width(SymW), .Depth(MaxLen)) u_txt (.aclk, .we(txt_we), .waddr(txt_wa),
        .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd));

    logic acc, s_mode, s_fin, out_free;
    assign s_mode   = s_axis_tuser[0];
    assign s_fin    = s_axis_tuser[1];
    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign acc = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

    logic [LenW-1:0] row_w;   // row wrapped into block
    assign row_w = (row_reg >= len_reg) ? '0 : row_reg;

    always_comb begin
        state_next = state_reg; len_next = len_reg; rp_next = rp_reg;
        ovf_next = ovf_reg; dv_next = dv_reg; pend_next = pend_reg;
        sym_next = sym_reg; fin_next = fin_reg; idx_next = idx_reg;
        sum_next = sum_reg; found_next = found_reg; small_next = small_reg;
        row_next = row_reg; k_next = k_reg; rk_next = rk_reg;
        ov_next = ov_reg && !m_axis_tready; od_next = od_reg; ou_next = ou_reg;
        col_we = 1'b0; rnk_we = 1'b0; cnt_we = 1'b0; st_we = 1'b0; txt_we = 1'b0;
        col_wa = len_reg[AddrW-1:0]; col_wd = sym_reg; rnk_wd = cnt_rd;
        col_ra = row_w[AddrW-1:0];
        cnt_wa = idx_reg[7:0]; cnt_wd = '0; cnt_ra = sym_reg;
        st_wa = idx_reg[7:0] - 8'd1; st_wd = sum_reg; st_ra = col_rd;
        txt_wa = '0; txt_wd = small_reg; txt_ra = rp_reg[AddrW-1:0];
        case (state_reg)
            S_CLR: begin
                cnt_we = 1'b1;
                idx_next = idx_reg + 9'd1;
                if (idx_reg == 9'd255) begin
                    idx_next = '0;
                    state_next = pend_reg ? S_LCNT : S_IDLE;
                    pend_next = 1'b0;
                end
            end
            S_IDLE: begin
                if (acc && s_mode == MODE_LOAD) begin
                    sym_next = s_axis_tdata; fin_next = s_fin;
                    cnt_ra = s_axis_tdata;
                    if (dv_reg) begin
                        len_next = '0; rp_next = '0; ovf_next = 1'b0; dv_next = 1'b0;
                        pend_next = 1'b1; idx_next = '0; state_next = S_CLR;
                    end else begin
                        state_next = S_LCNT;
                    end
                end else if (acc) begin
                    state_next = S_RD;
                end
            end
            S_LCNT: state_next = S_LWR;
            S_LWR: begin
                if (len_reg < LenW'(MaxLen)) begin
                    col_we = 1'b1; rnk_we = 1'b1; cnt_we = 1'b1;
                    cnt_wa = sym_reg; cnt_wd = cnt_rd + 1'b1;
                    len_next = len_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                if (fin_reg) begin
                    idx_next = '0; sum_next = '0; found_next = 1'b0; small_next = '0;
                    state_next = S_PFX;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_PFX: begin
                // issue read of idx, consume data of idx-1
                cnt_ra = idx_reg[7:0];
                if (idx_reg != 9'd0) begin
                    st_we = 1'b1;
                    sum_next = sum_reg + cnt_rd;
                    if (!found_reg && cnt_rd != '0) begin
                        found_next = 1'b1; small_next = st_wa;
                    end
                end
                idx_next = idx_reg + 9'd1;
                if (idx_reg == 9'd256) begin
                    rp_next = '0; dv_next = 1'b1;
                    row_next = '0; k_next = LenW'(1);
                    if (len_reg == '0) state_next = S_IDLE;
                    else state_next = S_WNXT;
                end
            end
            S_WNXT: begin
                // write the sentinel slot on first entry (k==1)
                if (k_reg == LenW'(1)) begin
                    txt_we = 1'b1; txt_wa = AddrW'(len_reg - 1'b1); txt_wd = small_reg;
                end
                if (k_reg >= len_reg) state_next = S_IDLE;
                else begin
                    row_next = row_w; state_next = S_WROW;  // col_ra = row_w issued
                end
            end
            S_WROW: begin
                txt_we = 1'b1; txt_wa = AddrW'(len_reg - 1'b1 - k_reg); txt_wd = col_rd;
                rk_next = rnk_rd; state_next = S_WST;   // st_ra = col_rd issued
            end
            S_WST: begin
                row_next = st_rd + rk_reg;
                k_next = k_reg + 1'b1;
                col_ra = AddrW'((st_rd + rk_reg >= len_reg) ? '0 : st_rd + rk_reg);
                if (k_reg + 1'b1 >= len_reg) state_next = S_IDLE;
                else state_next = S_WROW;
            end
            S_RD: state_next = S_RDW;
            S_RDW: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    if (!dv_reg || rp_reg >= len_reg) begin
                        od_next = '0; ou_next = {STAT_EMPTY, 1'b0};
                    end else begin
                        od_next = {6'd0, PosW'(rp_reg), txt_rd};
                        ou_next = {ovf_reg ? STAT_TRUNC : STAT_OK,
                                   (rp_reg + 1'b1 == len_reg)};
                        rp_next = rp_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR; len_reg <= '0; rp_reg <= '0; ovf_reg <= 1'b0;
            dv_reg <= 1'b0; pend_reg <= 1'b0; idx_reg <= '0; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next; len_reg <= len_next; rp_reg <= rp_next;
            ovf_reg <= ovf_next; dv_reg <= dv_next; pend_reg <= pend_next;
            idx_reg <= idx_next; ov_reg <= ov_next;
        end
        sym_reg <= sym_next; fin_reg <= fin_next; sum_reg <= sum_next;
        found_reg <= found_next; small_reg <= small_next; row_reg <= row_next;
        k_reg <= k_next; rk_reg <= rk_next;
        od_reg <= od_next; ou_reg <= ou_next;
    end

`ifndef SYNTHESIS
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LenW'(MaxLen)) else $error("length past capacity");
    a_rp: assert property (@(posedge aclk) disable iff (!aresetn)
        rp_reg <= len_reg) else $error("read pointer past length");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/bwt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module bwt_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: test/tb_bwt_inverse_decoder.sv
// Testbench for bwt_inverse_decoder: random and directed load/read traffic with
// a transaction-level inverse BWT model checking every returned byte.
// Depends on bwt_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_bwt_inverse_decoder;
    import bwt_pkg::*;

    typedef struct packed {
        logic [7:0]       byte_out;
        logic [PosW-1:0]  position;
        logic             end_of_text;
        logic [StatW-1:0] status;
    } text_byte_t;

    // Mirror of the decoder's state; predicts the byte each read returns.
    class bwt_text_model;
        logic [7:0]      last_col[MaxLen];
        int              rank_of[MaxLen];
        int              sym_count[NSym];
        int              sym_start[NSym];
        logic [7:0]      text[MaxLen];
        int              blk_len;
        int              rd_ptr;
        bit              truncated;
        bit              text_ready;
        text_byte_t      pending_bytes[$];
        int              errors;

        function void reset_state();
            foreach (sym_count[i]) sym_count[i] = 0;
            blk_len = 0;
            rd_ptr = 0;
            truncated = 0;
            text_ready = 0;
            pending_bytes.delete();
            errors = 0;
        endfunction

        // Start table by prefix sums, then LF walk from row 0 filling from the end.
        function void invert_block();
            int sum;
            int row;
            int smallest;
            bit found;
            logic [7:0] b;
            sum = 0;
            row = 0;
            smallest = 0;
            found = 0;
            for (int c = 0; c < NSym; c++) begin
                sym_start[c] = sum;
                sum += sym_count[c];
                if (!found && sym_count[c] != 0) begin
                    smallest = c;
                    found = 1;
                end
            end
            if (blk_len == 0) return;
            text[blk_len-1] = smallest[7:0];
            for (int k = 1; k < blk_len; k++) begin
                if (row >= blk_len) row = 0;
                b = last_col[row];
                text[blk_len-1-k] = b;
                row = sym_start[b] + rank_of[row];
            end
        endfunction

        function void note_transaction(logic mode, logic [7:0] sym, logic final_req);
            text_byte_t r;
            if (mode == MODE_LOAD) begin
                if (text_ready) begin
                    foreach (sym_count[i]) sym_count[i] = 0;
                    blk_len = 0;
                    rd_ptr = 0;
                    truncated = 0;
                    text_ready = 0;
                end
                if (blk_len < MaxLen) begin
                    last_col[blk_len] = sym;
                    rank_of[blk_len] = sym_count[sym];
                    sym_count[sym]++;
                    blk_len++;
                end else begin
                    truncated = 1;
                end
                if (final_req) begin
                    invert_block();
                    rd_ptr = 0;
                    text_ready = 1;
                end
                return;
            end
            if (!text_ready || rd_ptr >= blk_len) begin
                r = '{8'd0, '0, 1'b0, STAT_EMPTY};
            end else begin
                r.byte_out = text[rd_ptr];
                r.position = rd_ptr[PosW-1:0];
                r.end_of_text = (rd_ptr + 1 == blk_len);
                r.status = truncated ? STAT_TRUNC : STAT_OK;
                rd_ptr++;
            end
            pending_bytes.push_back(r);
        endfunction

        function void check_byte(text_byte_t got);
            text_byte_t want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected result transaction %p", got);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.byte_out !== want.byte_out) begin
                $error("byte_out: expected %0d, got %0d", want.byte_out, got.byte_out);
                errors++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.end_of_text !== want.end_of_text) begin
                $error("end_of_text: expected %0d, got %0d",
                       want.end_of_text, got.end_of_text);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;     // mode, final_req
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // byte_out, position, zero pad
    logic [2:0]  m_axis_tuser;          // end_of_text, status

    bwt_text_model text_model = new();
    int          sent_count;
    int          ready_hold;

    bwt_inverse_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly back-to-back, sometimes a short gap, rarely a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: check at the handshake edge, then choose the next ready level.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                text_model.check_byte('{m_axis_tdata[7:0], m_axis_tdata[17:8],
                                        m_axis_tuser[0], m_axis_tuser[2:1]});
            if (ready_hold > 0) begin
                ready_hold <= ready_hold - 1;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 20) begin
                ready_hold <= pick_gap();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // One input transaction; valid stays high when the next one follows at once.
    task automatic send_item(logic mode, logic [7:0] sym, logic final_req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= {final_req, mode};
        do @(posedge aclk); while (!s_axis_tready);
        text_model.note_transaction(mode, sym, final_req);
        sent_count++;
    endtask

    task automatic read_bytes(int n);
        for (int i = 0; i < n; i++)
            send_item(MODE_READ, 8'($urandom), 1'($urandom));
    endtask

    // Hold off the sender until every predicted byte has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (text_model.pending_bytes.size() != 0) @(posedge aclk);
    endtask

    // Loads one block. flavor 0: unique zero sentinel, 1: small alphabet,
    // 2: fully random bytes (sentinel may be missing).
    task automatic load_block(int len, int flavor);
        int sentinel_at;
        logic [7:0] sym;
        sentinel_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            case (flavor)
                0: sym = (i == sentinel_at) ? 8'd0 : 8'($urandom_range(1, 255));
                1: sym = 8'($urandom_range(250, 255));
                default: sym = 8'($urandom);
            endcase
            // occasional stray read during the load: new block not decoded yet (before the first byte, the old block)
            if ($urandom_range(0, 49) == 0) read_bytes(1);
            send_item(MODE_LOAD, sym, i == len - 1);
        end
    endtask

    initial begin
        #(12ns * 600000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int len;
        text_model.reset_state();
        sent_count = 0;
        ready_hold = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reads with nothing decoded yet.
        read_bytes(2);
        // Single-byte block of the top symbol, read past its end.
        send_item(MODE_LOAD, 8'd255, 1'b1);
        read_bytes(2);
        // Extremes with a zero sentinel.
        send_item(MODE_LOAD, 8'd255, 1'b0);
        send_item(MODE_LOAD, 8'd0, 1'b0);
        send_item(MODE_LOAD, 8'd128, 1'b0);
        send_item(MODE_LOAD, 8'd255, 1'b1);
        read_bytes(5);
        // No unique smallest byte: walk still followed.
        send_item(MODE_LOAD, 8'd7, 1'b0);
        send_item(MODE_LOAD, 8'd7, 1'b0);
        send_item(MODE_LOAD, 8'd7, 1'b1);
        read_bytes(2);
        // New block started before the old one was fully read.
        send_item(MODE_LOAD, 8'd1, 1'b0);
        send_item(MODE_LOAD, 8'd0, 1'b1);
        read_bytes(3);
        wait_drained();

        // Capacity: full block plus dropped bytes, final on a dropped byte.
        for (int i = 0; i < MaxLen + 3; i++)
            send_item(MODE_LOAD, (i == 517) ? 8'd0 : 8'($urandom_range(1, 255)),
                      i == MaxLen + 2);
        read_bytes(40);

        // Random blocks, mostly short.
        while (sent_count < 1750) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                              : $urandom_range(1, 40);
            load_block(len, ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
            read_bytes(($urandom_range(0, 4) == 0) ? $urandom_range(0, len)
                                                   : len + $urandom_range(0, 2));
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (300) @(posedge aclk);
        if (text_model.pending_bytes.size() != 0) begin
            $error("%0d expected results never arrived", text_model.pending_bytes.size());
            text_model.errors++;
        end
        if (text_model.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
